@@ sv/cmc_pkg.sv @@
// shared constants, path codes and side-band types of the color model converter
package cmc_pkg;

	localparam logic [15:0] FULL16   = 16'hFFFF;
	localparam logic [16:0] TWO_FULL = 17'd131070;
	localparam logic [31:0] DEN_RGB  = 32'hFFFF_0000;
	localparam logic [33:0] DD_HSL   = 34'h1_FFFC_0002;

	localparam logic [1:0] MODEL_RGBA  = 2'd0;
	localparam logic [1:0] MODEL_HSVA  = 2'd1;
	localparam logic [1:0] MODEL_HSLA  = 2'd2;
	localparam logic [1:0] MODEL_UNDEF = 2'd3;

	localparam int DIV_NUM_W = 49;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_QUO_W = 16;
	localparam int DIV_LAT   = DIV_QUO_W + 1;

	typedef enum logic [2:0] {
		PATH_COPY    = 3'd0,
		PATH_RGB2HSV = 3'd1,
		PATH_RGB2HSL = 3'd2,
		PATH_HSV2RGB = 3'd3,
		PATH_HSL2HSV = 3'd4,
		PATH_HSV2HSL = 3'd5,
		PATH_HSL2RGB = 3'd6
	} path_t;

	typedef struct packed {
		path_t       path;
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] lv;
		logic [15:0] alpha;
	} side1_t;

	typedef struct packed {
		path_t       path;
		logic [2:0]  sext;
		logic [15:0] hh;
		logic [15:0] ss;
		logic [15:0] tt;
		logic [15:0] alpha;
	} side2_t;

endpackage

@@ sv/cmc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module cmc_div
	import cmc_pkg::*;
#(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = DIV_DEN_W,
	parameter int QUO_W = DIV_QUO_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [NUM_W-1:0] num_s0;
	logic [DEN_W-1:0] den_s0;
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] bits_s [1:QUO_W];
	logic             ovf_s [1:QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= num;
			den_s0 <= den;
		end
	end

	for (genvar g = 1; g <= QUO_W; g++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] bits_in;
		logic             ovf_in;
		logic [DEN_W:0]   trial;
		logic             take;

		if (g == 1) begin : g_first
			// quotient must fit: top part of numerator below divisor
			assign rem_in  = DEN_W'(num_s0[NUM_W-1:QUO_W]);
			assign bits_in = num_s0[QUO_W-1:0];
			assign den_in  = den_s0;
			assign ovf_in  = CMP_W'(num_s0[NUM_W-1:QUO_W]) >= CMP_W'(den_s0);
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign bits_in = bits_s[g-1];
			assign den_in  = den_s[g-1];
			assign ovf_in  = ovf_s[g-1];
		end

		assign trial = {rem_in, bits_in[QUO_W-1]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				bits_s[g] <= {bits_in[QUO_W-2:0], take};
				den_s[g]  <= den_in;
				ovf_s[g]  <= ovf_in;
			end
		end
	end

	assign quo = ovf_s[QUO_W] ? {QUO_W{1'b1}} : bits_s[QUO_W];

endmodule

@@ sv/color_model_converter.sv @@
// color model converter top level: rgba / hsva / hsla conversion pipeline
//
//  channel | dir | signals                      | word
//  --------+-----+------------------------------+-------------------------------------
//  input   | in  | s_tvalid s_tready s_tdata/tuser | color channels, alpha; models in tuser
//  output  | out | m_tvalid m_tready m_tdata     | converted channels, alpha
//
//  one word per clock while the skid register is empty; stages: 3 front stages, 17-stage divider,
//  3 middle stages, product stage, output register
//  the first-pass divider pipelines set the depth; each resolves one quotient bit per stage
//  the second pass divides by 65535 with a shift and add beside the output register
//  reset clears valid bits only; no clearing pass, the block accepts right after reset
//  a full skid register stops the whole pipeline; s_tready is that register's empty flag
module color_model_converter
	import cmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // first_channel, second_channel, third_channel, alpha_in
	input  logic [3:0]  s_tuser,   // target_model, source_model
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // out_first, out_second, out_third, alpha_out
);

	logic en;

	// front stage 1: capture and path decode
	logic [1:0]  tgt, src;
	path_t       path_dec;
	logic        vld_s1;
	path_t       path_s1;
	logic [15:0] c0_s1, c1_s1, c2_s1, alpha_s1;

	assign tgt = s_tuser[1:0];
	assign src = (s_tuser[3:2] == MODEL_UNDEF) ? MODEL_RGBA : s_tuser[3:2];

	always_comb begin
		path_dec = PATH_COPY;
		if (tgt != src) begin
			case (tgt)
				MODEL_RGBA: path_dec = (src == MODEL_HSVA) ? PATH_HSV2RGB : PATH_HSL2RGB;
				MODEL_HSVA: path_dec = (src == MODEL_RGBA) ? PATH_RGB2HSV : PATH_HSL2HSV;
				MODEL_HSLA: path_dec = (src == MODEL_RGBA) ? PATH_RGB2HSL : PATH_HSV2HSL;
				default:    path_dec = PATH_COPY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			path_s1  <= path_dec;
			c0_s1    <= s_tdata[15:0];
			c1_s1    <= s_tdata[31:16];
			c2_s1    <= s_tdata[47:32];
			alpha_s1 <= s_tdata[63:48];
		end
	end

	// stage 2: max, min and hsl lightness distance
	logic [15:0] mx_rg, mn_rg;
	logic        vld_s2;
	path_t       path_s2;
	logic [15:0] c0_s2, c1_s2, c2_s2, alpha_s2, mx_s2, mn_s2, m_s2;

	assign mx_rg = (c0_s1 > c1_s1) ? c0_s1 : c1_s1;
	assign mn_rg = (c0_s1 < c1_s1) ? c0_s1 : c1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			path_s2  <= path_s1;
			c0_s2    <= c0_s1;
			c1_s2    <= c1_s1;
			c2_s2    <= c2_s1;
			alpha_s2 <= alpha_s1;
			mx_s2    <= (c2_s1 > mx_rg) ? c2_s1 : mx_rg;
			mn_s2    <= (c2_s1 < mn_rg) ? c2_s1 : mn_rg;
			m_s2     <= (c2_s1 < (FULL16 - c2_s1)) ? c2_s1 : (FULL16 - c2_s1);
		end
	end

	// stage 3: chroma, sum and the products
	logic [15:0] d_w;
	logic        vld_s3;
	path_t       path_s3;
	logic [15:0] c0_s3, c1_s3, c2_s3, alpha_s3, mx_s3, d_s3;
	logic [18:0] d6_s3;
	logic [16:0] sum_s3;
	logic [31:0] sm_s3, vs_s3, lf_s3;
	logic [32:0] ln_s3;

	assign d_w = mx_s2 - mn_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			path_s3  <= path_s2;
			c0_s3    <= c0_s2;
			c1_s3    <= c1_s2;
			c2_s3    <= c2_s2;
			alpha_s3 <= alpha_s2;
			mx_s3    <= mx_s2;
			d_s3     <= d_w;
			d6_s3    <= 19'({d_w, 2'b00}) + 19'({d_w, 1'b0});
			sum_s3   <= 17'(mx_s2) + 17'(mn_s2);
			sm_s3    <= 32'(c1_s2) * 32'(m_s2);
			vs_s3    <= 32'(c2_s2) * 32'(c1_s2);
			lf_s3    <= {c2_s2, 16'h0000} - 32'(c2_s2);
			ln_s3    <= 33'(c2_s2) * 33'(TWO_FULL - 17'(c1_s2));
		end
	end

	// divider operands for the first pass (registered in the divider entry)
	logic [18:0] hue_n;
	logic [33:0] vn, dl, mm, d1_raw, d2_raw, d1, d2;
	logic [16:0] sump;
	logic [31:0] d65535;
	logic [48:0] n1, n2;
	logic [15:0] q1, q2;
	side1_t      side_in1;

	always_comb begin
		if (c0_s3 == mx_s3) begin
			hue_n = (c1_s3 >= c2_s3) ? 19'(c1_s3 - c2_s3) : d6_s3 - 19'(c2_s3 - c1_s3);
		end else if (c1_s3 == mx_s3) begin
			hue_n = 19'({d_s3, 1'b0}) + 19'(c2_s3) - 19'(c0_s3);
		end else begin
			hue_n = 19'({d_s3, 2'b00}) + 19'(c0_s3) - 19'(c1_s3);
		end
	end

	assign vn     = 34'(sm_s3) + 34'(lf_s3);
	assign dl     = DD_HSL - 34'(ln_s3);
	assign mm     = (34'(ln_s3) < dl) ? 34'(ln_s3) : dl;
	assign sump   = (sum_s3 <= 17'(FULL16)) ? sum_s3 : TWO_FULL - sum_s3;
	assign d65535 = {d_s3, 16'h0000} - 32'(d_s3);

	always_comb begin
		case (path_s3)
			PATH_RGB2HSV: begin
				n1 = 49'(d65535);  d1_raw = 34'(mx_s3);
				n2 = 49'({hue_n, 16'h0000});  d2_raw = 34'(d6_s3);
			end
			PATH_RGB2HSL: begin
				n1 = 49'(d65535);  d1_raw = 34'(sump);
				n2 = 49'({hue_n, 16'h0000});  d2_raw = 34'(d6_s3);
			end
			PATH_HSL2HSV, PATH_HSL2RGB: begin
				n1 = 49'({sm_s3, 17'h00000}) - 49'({sm_s3, 1'b0});  d1_raw = vn;
				n2 = 49'(vn);  d2_raw = 34'(FULL16);
			end
			PATH_HSV2HSL: begin
				n1 = 49'({vs_s3, 16'h0000}) - 49'(vs_s3);  d1_raw = mm;
				n2 = 49'(ln_s3);  d2_raw = 34'(TWO_FULL);
			end
			default: begin
				n1 = '0;  d1_raw = 34'd1;
				n2 = '0;  d2_raw = 34'd1;
			end
		endcase
	end

	// a zero divisor only comes with a zero numerator: the answer is then zero
	assign d1 = (d1_raw == '0) ? 34'd1 : d1_raw;
	assign d2 = (d2_raw == '0) ? 34'd1 : d2_raw;

	always_comb begin
		side_in1.path  = path_s3;
		side_in1.c0    = c0_s3;
		side_in1.c1    = c1_s3;
		side_in1.c2    = c2_s3;
		side_in1.lv    = (path_s3 == PATH_RGB2HSV) ? mx_s3 : sum_s3[16:1];
		side_in1.alpha = alpha_s3;
	end

	cmc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .QUO_W(DIV_QUO_W)) u_div_a (
		.clk(clk), .en(en), .num(n1), .den(d1), .quo(q1)
	);
	cmc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .QUO_W(DIV_QUO_W)) u_div_b (
		.clk(clk), .en(en), .num(n2), .den(d2), .quo(q2)
	);

	// side-band delay line beside the first divider pass
	side1_t side_s4 [0:DIV_LAT-1];
	logic   vld_s4  [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4[0] <= side_in1;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s4[i] <= side_s4[i-1];
			end
		end
	end

	// stage 5: hsv / hsl intermediate
	side1_t      sd1;
	logic        vld_s5;
	path_t       path_s5;
	logic [15:0] hh_s5, ss_s5, tt_s5, alpha_s5;

	assign sd1 = side_s4[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			path_s5  <= sd1.path;
			alpha_s5 <= sd1.alpha;
			case (sd1.path)
				PATH_RGB2HSV, PATH_RGB2HSL: begin
					hh_s5 <= q2;  ss_s5 <= q1;  tt_s5 <= sd1.lv;
				end
				PATH_HSL2HSV, PATH_HSL2RGB, PATH_HSV2HSL: begin
					hh_s5 <= sd1.c0;  ss_s5 <= q1;  tt_s5 <= q2;
				end
				default: begin
					hh_s5 <= sd1.c0;  ss_s5 <= sd1.c1;  tt_s5 <= sd1.c2;
				end
			endcase
		end
	end

	// stage 6: sextant and fraction of the hue
	logic [18:0] h6;
	logic        vld_s6;
	path_t       path_s6;
	logic [2:0]  sext_s6;
	logic [15:0] f_s6, hh_s6, ss_s6, tt_s6, alpha_s6;

	assign h6 = 19'({hh_s5, 2'b00}) + 19'({hh_s5, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			path_s6  <= path_s5;
			sext_s6  <= h6[18:16];
			f_s6     <= h6[15:0];
			hh_s6    <= hh_s5;
			ss_s6    <= ss_s5;
			tt_s6    <= tt_s5;
			alpha_s6 <= alpha_s5;
		end
	end

	// stage 7: p, q, t factors
	logic [31:0] sf;
	logic        vld_s7;
	path_t       path_s7;
	logic [2:0]  sext_s7;
	logic [15:0] pa_s7, hh_s7, ss_s7, tt_s7, alpha_s7;
	logic [31:0] qa_s7, ta_s7;

	assign sf = 32'(ss_s6) * 32'(f_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			path_s7  <= path_s6;
			sext_s7  <= sext_s6;
			hh_s7    <= hh_s6;
			ss_s7    <= ss_s6;
			tt_s7    <= tt_s6;
			alpha_s7 <= alpha_s6;
			pa_s7    <= FULL16 - ss_s6;
			qa_s7    <= DEN_RGB - sf;
			// den - s*(65536-f) = den - s*65536 + s*f
			ta_s7    <= 32'(33'(DEN_RGB) - 33'({ss_s6, 16'h0000}) + 33'(sf));
		end
	end

	// stage 8: value times factor; q and t drop the low 16 bits of their scale
	logic [31:0] np;
	logic [47:0] nq, nt;
	side2_t      side_in2;
	logic        vld_s8;
	side2_t      side_s8;
	logic [31:0] np_s8, nq_s8, nt_s8;

	assign np = 32'(tt_s7) * 32'(pa_s7);
	assign nq = 48'(tt_s7) * 48'(qa_s7);
	assign nt = 48'(tt_s7) * 48'(ta_s7);

	always_comb begin
		side_in2.path  = path_s7;
		side_in2.sext  = sext_s7;
		side_in2.hh    = hh_s7;
		side_in2.ss    = ss_s7;
		side_in2.tt    = tt_s7;
		side_in2.alpha = alpha_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_in2;
			np_s8   <= np;
			nq_s8   <= nq[47:16];
			nt_s8   <= nt[47:16];
		end
	end

	// exact x / 65535 for any x below 2^32 whose quotient fits 16 bits
	function automatic logic [15:0] div65535(logic [31:0] x);
		logic [32:0] y;
		y = 33'(x) + 33'(x[31:16]) + 33'd1;
		return y[31:16];
	endfunction

	// final selection: sextant table for the paths into rgb, else the intermediate
	side2_t      sd2;
	logic [15:0] qp, qq, qt;
	logic [15:0] o0, o1, o2;
	logic [63:0] res_word;

	assign sd2 = side_s8;
	assign qp  = div65535(np_s8);
	assign qq  = div65535(nq_s8);
	assign qt  = div65535(nt_s8);

	always_comb begin
		if (sd2.path == PATH_HSV2RGB || sd2.path == PATH_HSL2RGB) begin
			case (sd2.sext)
				3'd0:    begin o0 = sd2.tt;  o1 = qt;      o2 = qp;     end
				3'd1:    begin o0 = qq;      o1 = sd2.tt;  o2 = qp;     end
				3'd2:    begin o0 = qp;      o1 = sd2.tt;  o2 = qt;     end
				3'd3:    begin o0 = qp;      o1 = qq;      o2 = sd2.tt; end
				3'd4:    begin o0 = qt;      o1 = qp;      o2 = sd2.tt; end
				default: begin o0 = sd2.tt;  o1 = qp;      o2 = qq;     end
			endcase
		end else begin
			o0 = sd2.hh;
			o1 = sd2.ss;
			o2 = sd2.tt;
		end
	end

	assign res_word = {sd2.alpha, o2, o1, o0};

	// output register plus skid register
	logic        out_vld_q, skid_vld_q;
	logic [63:0] out_data_q, skid_data_q;
	logic        push, pop;

	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign push     = en && vld_s8;
	assign pop      = out_vld_q && m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// valid bits of every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s4[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4[0] <= vld_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s4[i] <= vld_s4[i-1];
			end
			vld_s5    <= vld_s4[DIV_LAT-1];
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_data_q <= res_word;
			end else begin
				out_data_q <= res_word;
			end
		end
	end

endmodule
